### sv/nff_pkg.sv
// Shared constants, command/status types and helpers for the next-fit frame allocator.
package nff_pkg;

  localparam int NUM_FRAMES  = 1024;
  localparam int FRAME_SHIFT = 12;                  // log2 of the 4096-byte frame size
  localparam int MAX_RUN     = 64;
  localparam int WORD_BITS   = 32;
  localparam int MAP_WORDS   = NUM_FRAMES / WORD_BITS;
  localparam int BIT_W       = $clog2(WORD_BITS);
  localparam int WORD_W      = $clog2(MAP_WORDS);
  localparam int FRAME_W     = $clog2(NUM_FRAMES);  // frame index
  localparam int IDX_W       = FRAME_W + 1;         // frame position, can hold NUM_FRAMES
  localparam int ADDR_W      = 48;
  localparam int COUNT_W     = 7;

  // Opcodes
  localparam logic [1:0] OP_ALLOC_ONE = 2'd0;
  localparam logic [1:0] OP_ALLOC_RUN = 2'd1;
  localparam logic [1:0] OP_FREE      = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOSPACE  = 2'd1;
  localparam logic [1:0] ST_BADCOUNT = 2'd2;
  localparam logic [1:0] ST_RANGE    = 2'd3;

  // Configuration register indexes
  localparam logic REG_BASE_ADDRESS = 1'b0;
  localparam logic REG_FRAME_TOTAL  = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic decode;
    logic scan_one;
    logic scan_run;
    logic mark;
    logic emit;
  } nff_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic go_one;
    logic go_run;
    logic scan_end;
    logic run_hit;
    logic mark_last;
  } nff_sts_t;

  // Index of the lowest set bit of a map word, zero when none is set
  function automatic logic [BIT_W-1:0] first_set(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

endpackage

### sv/nff_ctrl.sv
// Controller state machine for the next-fit frame allocator.
module nff_ctrl
  import nff_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  nff_sts_t sts,
  output nff_cmd_t cmd,
  output logic     busy
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCAN1  = 3'd2;
  localparam logic [2:0] S_SCANR  = 3'd3;
  localparam logic [2:0] S_MARK   = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  // Sequence one item through decode, scan, mark and output
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        priority if (sts.go_one) state_next = S_SCAN1;
        else if (sts.go_run)     state_next = S_SCANR;
        else                     state_next = S_OUT;
      end
      S_SCAN1: begin
        cmd.scan_one = 1'b1;
        if (sts.scan_end) state_next = S_OUT;
      end
      S_SCANR: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_end) state_next = sts.run_hit ? S_MARK : S_OUT;
      end
      S_MARK: begin
        cmd.mark = 1'b1;
        if (sts.mark_last) state_next = S_OUT;
      end
      S_OUT: begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assign busy = (state != S_IDLE);

endmodule

### sv/nff_dp.sv
// Datapath for the next-fit frame allocator: used map, cursor, scan and result registers.
module nff_dp
  import nff_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  nff_cmd_t           cmd,
  output nff_sts_t           sts,
  input  logic [1:0]         op,
  input  logic [COUNT_W-1:0] run_length,
  input  logic [ADDR_W-1:0]  free_address,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [ADDR_W-1:0]  cfg_data,
  output logic [1:0]         status,
  output logic [FRAME_W-1:0] first_frame,
  output logic [ADDR_W-1:0]  frame_address,
  output logic               done
);

  localparam logic [WORD_BITS-1:0] ONES = '1;

  // Configuration
  logic [ADDR_W-1:0] base_address;
  logic [IDX_W-1:0]  frame_total;

  // Allocator state
  logic [WORD_BITS-1:0] map [MAP_WORDS];
  logic [IDX_W-1:0]     cursor;

  // Item and scan registers
  logic [1:0]         op_r;
  logic [COUNT_W-1:0] count_r;
  logic [ADDR_W:0]    diff_r;
  logic [IDX_W-1:0]   pos;
  logic [COUNT_W-1:0] run_cnt;
  logic [IDX_W-1:0]   run_start;
  logic [IDX_W-1:0]   mark_end;
  logic [1:0]         res_status;
  logic [FRAME_W-1:0] res_frame;
  logic               res_ok;

  logic [IDX_W-1:0]     lim;
  logic [WORD_W-1:0]    w_idx;
  logic [BIT_W-1:0]     b_idx;
  logic [WORD_BITS-1:0] word;
  logic [WORD_BITS-1:0] above;
  logic [WORD_BITS-1:0] free_vec;
  logic [WORD_BITS-1:0] used_vec;
  logic [BIT_W-1:0]     ff;
  logic [BIT_W-1:0]     fu;
  logic                 any_free;
  logic                 any_used;
  logic                 pos_out;
  logic [WORD_W:0]      next_word;
  logic [IDX_W-1:0]     next_start;
  logic [IDX_W-1:0]     g_one;
  logic [IDX_W-1:0]     g_run;
  logic [IDX_W-1:0]     e_run;
  logic [IDX_W-1:0]     gap;
  logic [COUNT_W-1:0]   need;
  logic                 run_hit_c;
  logic                 count_ok;
  logic                 in_range;
  logic [IDX_W-1:0]     free_idx;
  logic                 mark_last_c;
  logic [BIT_W-1:0]     mark_hi;
  logic [WORD_BITS-1:0] mark_mask;

  // Limit the active frame count to the built capacity
  assign lim = (frame_total > IDX_W'(NUM_FRAMES)) ? IDX_W'(NUM_FRAMES) : frame_total;

  // Read the map word under the scan position
  assign w_idx    = pos[FRAME_W-1:BIT_W];
  assign b_idx    = pos[BIT_W-1:0];
  assign word     = map[w_idx];
  assign above    = ONES << b_idx;
  assign free_vec = ~word & above;
  assign used_vec = word & above;
  assign ff       = first_set(free_vec);
  assign fu       = first_set(used_vec);
  assign any_free = |free_vec;
  assign any_used = |used_vec;
  assign pos_out  = (pos >= lim);

  // Next stop of the scan: first hit in this word, else the next word's start
  assign next_word  = {1'b0, w_idx} + (WORD_W + 1)'(1);
  assign next_start = {next_word, BIT_W'(0)};
  assign g_one      = any_free ? {1'b0, w_idx, ff} : next_start;
  assign g_run      = any_used ? {1'b0, w_idx, fu} : next_start;
  assign e_run      = (g_run > lim) ? lim : g_run;
  assign gap        = e_run - pos;
  assign need       = count_r - run_cnt;
  assign run_hit_c  = !pos_out && (COUNT_W'(gap) >= need);

  // Classify the item
  assign count_ok = (count_r != '0) && (count_r <= COUNT_W'(MAX_RUN));
  assign free_idx = diff_r[FRAME_SHIFT +: IDX_W];
  assign in_range = !diff_r[ADDR_W]
                 && (diff_r[ADDR_W-1:FRAME_SHIFT+IDX_W] == '0)
                 && (free_idx < lim);

  // Mask of the run bits in the word under the mark pointer
  assign mark_last_c = (mark_end[FRAME_W-1:BIT_W] == w_idx);
  assign mark_hi     = mark_last_c ? mark_end[BIT_W-1:0] : BIT_W'(WORD_BITS - 1);
  assign mark_mask   = (ONES << b_idx) & (ONES >> (BIT_W'(WORD_BITS - 1) - mark_hi));

  always_comb begin
    sts.go_one    = (op_r == OP_ALLOC_ONE);
    sts.go_run    = (op_r == OP_ALLOC_RUN) && count_ok;
    sts.scan_end  = (op_r == OP_ALLOC_ONE)
                  ? (pos_out || (g_one >= lim) || any_free)
                  : (run_hit_c || pos_out || (g_run >= lim));
    sts.run_hit   = run_hit_c;
    sts.mark_last = mark_last_c;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      frame_total  <= IDX_W'(NUM_FRAMES);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE_ADDRESS: base_address <= cfg_data;
        REG_FRAME_TOTAL:  frame_total  <= cfg_data[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // Update the used map: set on a single allocation, clear on free, fill runs
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAP_WORDS; i++) map[i] <= '0;
    end else begin
      if (cmd.scan_one && !pos_out && (g_one < lim) && any_free)
        map[w_idx][ff] <= 1'b1;
      if (cmd.decode && (op_r == OP_FREE) && in_range)
        map[free_idx[FRAME_W-1:BIT_W]][free_idx[BIT_W-1:0]] <= 1'b0;
      if (cmd.mark)
        map[w_idx] <= word | mark_mask;
    end
  end

  // Cursor
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
    end else begin
      if (cmd.decode && (op_r == OP_FREE) && in_range)
        cursor <= free_idx;
      if (cmd.scan_one && !pos_out) begin
        if (g_one >= lim)  cursor <= lim;
        else if (any_free) cursor <= g_one + IDX_W'(1);
      end
      if (cmd.scan_run && run_hit_c)
        cursor <= cursor + IDX_W'(1);
    end
  end

  // Item latch, scan progress and pending result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= op;
      count_r   <= run_length;
      diff_r    <= {1'b0, free_address} - {1'b0, base_address};
      pos       <= cursor;
      run_cnt   <= '0;
      run_start <= cursor;
    end
    if (cmd.decode) begin
      if ((op_r == OP_FREE) && in_range) begin
        res_ok     <= 1'b1;
        res_frame  <= free_idx[FRAME_W-1:0];
        res_status <= ST_OK;
      end else begin
        res_ok     <= 1'b0;
        res_frame  <= '0;
        res_status <= (op_r == OP_FREE) ? ST_RANGE : ST_BADCOUNT;
      end
    end
    if (cmd.scan_one) begin
      priority if (pos_out || (g_one >= lim)) begin
        res_ok     <= 1'b0;
        res_frame  <= '0;
        res_status <= ST_NOSPACE;
      end else if (any_free) begin
        res_ok     <= 1'b1;
        res_frame  <= g_one[FRAME_W-1:0];
        res_status <= ST_OK;
      end else begin
        pos <= g_one;
      end
    end
    if (cmd.scan_run) begin
      priority if (pos_out) begin
        res_ok     <= 1'b0;
        res_frame  <= '0;
        res_status <= ST_NOSPACE;
      end else if (run_hit_c) begin
        res_ok     <= 1'b1;
        res_frame  <= run_start[FRAME_W-1:0];
        res_status <= ST_OK;
        pos        <= run_start;
        mark_end   <= run_start + IDX_W'(count_r) - IDX_W'(1);
      end else if (g_run >= lim) begin
        res_ok     <= 1'b0;
        res_frame  <= '0;
        res_status <= ST_NOSPACE;
      end else if (any_used) begin
        // restart the run after the used frame
        run_start <= g_run + IDX_W'(1);
        run_cnt   <= '0;
        pos       <= g_run + IDX_W'(1);
      end else begin
        run_cnt <= run_cnt + COUNT_W'(gap);
        pos     <= g_run;
      end
    end
    if (cmd.mark)
      pos <= next_start;
  end

  // Register the result; it is held until the next result
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status        <= res_status;
      first_frame   <= res_frame;
      frame_address <= res_ok ? base_address + (ADDR_W'(res_frame) << FRAME_SHIFT) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= cmd.emit;
  end

endmodule

### sv/next_fit_frame_allocator.sv
// Top level of the next-fit frame allocator.
//
// Usage:
//   Requests go in on start/busy: a request (op, run_length, free_address)
//   is taken at a clock edge with start high and busy low. Each request
//   gives one result on status, first_frame and frame_address, shown for
//   exactly one cycle with done high; the receiver cannot stall it.
//   Configuration (base_address index 0, frame_total index 1) is written
//   through cfg_we/cfg_index/cfg_data while busy is low.
// Sequencing:
//   A free or a rejected request passes through decode and output only.
//   Allocate-one adds a scan step per 32-frame map word scanned.
//   Allocate-run adds a scan step per map word crossed plus one per used
//   frame met, then marks the run one map word per step.
//   A new request can be accepted in the cycle done is high.
// Reset:
//   rst clears the used map (all frames free), the cursor, base_address and
//   sets frame_total to 1024.
module next_fit_frame_allocator
  import nff_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         op,
  input  logic [COUNT_W-1:0] run_length,
  input  logic [ADDR_W-1:0]  free_address,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [ADDR_W-1:0]  cfg_data,
  output logic [1:0]         status,
  output logic [FRAME_W-1:0] first_frame,
  output logic [ADDR_W-1:0]  frame_address,
  output logic               done
);

  nff_cmd_t cmd;
  nff_sts_t sts;

  nff_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  nff_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .op            (op),
    .run_length    (run_length),
    .free_address  (free_address),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .status        (status),
    .first_frame   (first_frame),
    .frame_address (frame_address),
    .done          (done)
  );

  // An accepted item keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // A result is shown only after the block has gone idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  // Results never come in adjacent cycles
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  // Failed items carry zero frame and address
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != ST_OK)) |-> ((first_frame == '0) && (frame_address == '0)))
    else $error("failed result carries a frame");

endmodule
